### src/mqtt_rx_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mqtt_rx_pkg
// Shared types and codes for the MQTT receive packet parser.
// ---------------------------------------------------------------------------
package mqtt_rx_pkg;

   // parse phases, one-hot
   typedef enum logic [8:0] {
      PH_FLAGS   = 9'b000000001,
      PH_LEN     = 9'b000000010,
      PH_TLEN    = 9'b000000100,
      PH_TOPIC   = 9'b000001000,
      PH_ID      = 9'b000010000,
      PH_PAYLOAD = 9'b000100000,
      PH_BODY    = 9'b001000000,
      PH_SKIP    = 9'b010000000,
      PH_ERR     = 9'b100000000
   } phase_type;

   // byte classification codes
   localparam logic [2:0] KIND_FLAGS     = 3'd0;
   localparam logic [2:0] KIND_LENGTH    = 3'd1;
   localparam logic [2:0] KIND_TOPIC_LEN = 3'd2;
   localparam logic [2:0] KIND_TOPIC     = 3'd3;
   localparam logic [2:0] KIND_MSG_ID    = 3'd4;
   localparam logic [2:0] KIND_PAYLOAD   = 3'd5;
   localparam logic [2:0] KIND_BODY      = 3'd6;
   localparam logic [2:0] KIND_DISCARD   = 3'd7;

   // format error codes
   localparam logic [1:0] FERR_NONE    = 2'd0;
   localparam logic [1:0] FERR_LENGTH  = 2'd1;
   localparam logic [1:0] FERR_OVERRUN = 2'd2;

   // control packet types
   localparam logic [3:0] TYPE_PUBLISH  = 4'd3;
   localparam logic [3:0] TYPE_UNSUBACK = 4'd11;

   localparam logic [2:0] LEN_BYTES_MAX = 3'd4;

   typedef struct packed {
      phase_type   phase;
      logic [3:0]  ptype;
      logic [1:0]  qos;
      logic [27:0] len_accum;
      logic [2:0]  byte_cnt;
      logic [27:0] body_left;
      logic [15:0] topic_size;
      logic [15:0] topic_left;
      logic [15:0] msg_id;
      logic [27:0] pay_len;
   } parse_state_type;

   typedef struct packed {
      logic [2:0]  byte_kind;
      logic [7:0]  data_byte;
      logic [3:0]  packet_type;
      logic [1:0]  qos_level;
      logic [27:0] remaining_length;
      logic [15:0] topic_length;
      logic [15:0] packet_id;
      logic [27:0] payload_length;
      logic        end_of_packet;
      logic [1:0]  format_error;
   } result_type;

endpackage

### src/mqtt_rx_step_logic.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mqtt_rx_step_logic
// Per-byte parse step: next parser state and the result beat for one byte.
// ---------------------------------------------------------------------------
module mqtt_rx_step_logic (
   input  mqtt_rx_pkg::parse_state_type st,
   input  logic [7:0]                   rx_byte,
   output mqtt_rx_pkg::parse_state_type st_next,
   output mqtt_rx_pkg::result_type      result
);
   import mqtt_rx_pkg::*;

   typedef struct packed {
      phase_type phase;
      logic      eop;
      logic      overrun;
   } enter_type;

   // phase change guarded by a check that enough body bytes remain
   function automatic enter_type enter_phase(input phase_type nxt,
                                             input logic [16:0] need,
                                             input logic [27:0] left);
      enter_type r;
      r.phase   = nxt;
      r.eop     = 1'b0;
      r.overrun = 1'b0;
      if ({11'b0, need} > left) begin
         r.overrun = 1'b1;
         if (left == 28'd0) begin
            r.eop   = 1'b1;
            r.phase = PH_FLAGS;
         end else begin
            r.phase = PH_SKIP;
         end
      end else if (left == 28'd0) begin
         r.eop   = 1'b1;
         r.phase = PH_FLAGS;
      end
      return r;
   endfunction

   logic [27:0] body_dec;
   logic [27:0] len_group;
   logic [27:0] accum_new;
   logic [15:0] tlen_new;
   logic [16:0] need;
   logic        qos_nz;
   logic        in_body;
   logic        eop;
   logic        overrun;
   logic [2:0]  kind;
   enter_type   ent;

   assign body_dec = st.body_left - {27'b0, |st.body_left};
   assign qos_nz   = (st.qos != 2'd0);
   assign tlen_new = {st.topic_size[7:0], rx_byte};
   assign need     = {1'b0, tlen_new} + (qos_nz ? 17'd2 : 17'd0);

   // 7-bit length group placed by its byte position
   always_comb begin
      case (st.byte_cnt[1:0])
         2'd0:    len_group = {21'b0, rx_byte[6:0]};
         2'd1:    len_group = {14'b0, rx_byte[6:0], 7'b0};
         2'd2:    len_group = {7'b0, rx_byte[6:0], 14'b0};
         default: len_group = {rx_byte[6:0], 21'b0};
      endcase
   end
   assign accum_new = st.len_accum | len_group;

   always_comb begin
      st_next = st;
      kind    = KIND_DISCARD;
      eop     = 1'b0;
      overrun = 1'b0;
      in_body = 1'b0;
      ent     = '{phase: PH_FLAGS, eop: 1'b0, overrun: 1'b0};
      unique case (st.phase)
         PH_FLAGS: begin
            kind               = KIND_FLAGS;
            st_next.ptype      = rx_byte[7:4];
            st_next.qos        = rx_byte[2:1];
            st_next.len_accum  = '0;
            st_next.byte_cnt   = '0;
            st_next.body_left  = '0;
            st_next.topic_size = '0;
            st_next.topic_left = '0;
            st_next.msg_id     = '0;
            st_next.pay_len    = '0;
            st_next.phase      = PH_LEN;
         end
         PH_LEN: begin
            if (st.byte_cnt >= LEN_BYTES_MAX) begin
               st_next.phase = PH_ERR;
            end else begin
               kind              = KIND_LENGTH;
               st_next.len_accum = accum_new;
               st_next.byte_cnt  = st.byte_cnt + 3'd1;
               if (!rx_byte[7]) begin
                  st_next.byte_cnt  = '0;
                  st_next.body_left = accum_new;
                  if (st.ptype == TYPE_PUBLISH) begin
                     ent = enter_phase(PH_TLEN, 17'd2, accum_new);
                  end else if (st.ptype > TYPE_PUBLISH && st.ptype <= TYPE_UNSUBACK) begin
                     ent = enter_phase(PH_ID, 17'd2, accum_new);
                  end else begin
                     ent = enter_phase(PH_BODY, 17'd0, accum_new);
                  end
                  st_next.phase = ent.phase;
                  eop           = ent.eop;
                  overrun       = ent.overrun;
               end
            end
         end
         PH_TLEN: begin
            in_body            = 1'b1;
            kind               = KIND_TOPIC_LEN;
            st_next.body_left  = body_dec;
            st_next.topic_size = tlen_new;
            st_next.byte_cnt   = st.byte_cnt + 3'd1;
            if (st.byte_cnt != 3'd0) begin
               st_next.byte_cnt   = '0;
               st_next.topic_left = tlen_new;
               if ({11'b0, need} <= body_dec) begin
                  st_next.pay_len = body_dec - {11'b0, need};
               end
               if (tlen_new != 16'd0) begin
                  ent = enter_phase(PH_TOPIC, need, body_dec);
               end else begin
                  ent = enter_phase(qos_nz ? PH_ID : PH_PAYLOAD, need, body_dec);
               end
               st_next.phase = ent.phase;
               eop           = ent.eop;
               overrun       = ent.overrun;
            end
         end
         PH_TOPIC: begin
            in_body            = 1'b1;
            kind               = KIND_TOPIC;
            st_next.body_left  = body_dec;
            st_next.topic_left = st.topic_left - {15'b0, |st.topic_left};
            if (st_next.topic_left == 16'd0) begin
               ent           = enter_phase(qos_nz ? PH_ID : PH_PAYLOAD, 17'd0, body_dec);
               st_next.phase = ent.phase;
               eop           = ent.eop;
            end
         end
         PH_ID: begin
            in_body           = 1'b1;
            kind              = KIND_MSG_ID;
            st_next.body_left = body_dec;
            st_next.msg_id    = {st.msg_id[7:0], rx_byte};
            st_next.byte_cnt  = st.byte_cnt + 3'd1;
            if (st.byte_cnt != 3'd0) begin
               st_next.byte_cnt = '0;
               ent = enter_phase((st.ptype == TYPE_PUBLISH) ? PH_PAYLOAD : PH_BODY,
                                 17'd0, body_dec);
               st_next.phase = ent.phase;
               eop           = ent.eop;
            end
         end
         PH_PAYLOAD: begin
            in_body           = 1'b1;
            kind              = KIND_PAYLOAD;
            st_next.body_left = body_dec;
         end
         PH_BODY: begin
            in_body           = 1'b1;
            kind              = KIND_BODY;
            st_next.body_left = body_dec;
         end
         PH_SKIP: begin
            in_body           = 1'b1;
            overrun           = 1'b1;
            st_next.body_left = body_dec;
         end
         PH_ERR: begin
            kind = KIND_DISCARD;
         end
         default: begin
            st_next.phase = PH_ERR;
         end
      endcase
      // last body byte closes the packet
      if (in_body && body_dec == 28'd0 && st_next.phase != PH_FLAGS) begin
         eop           = 1'b1;
         st_next.phase = PH_FLAGS;
      end
   end

   always_comb begin
      result.byte_kind        = kind;
      result.data_byte        = rx_byte;
      result.packet_type      = st_next.ptype;
      result.qos_level        = st_next.qos;
      result.remaining_length = st_next.len_accum;
      result.topic_length     = (st_next.ptype == TYPE_PUBLISH) ? st_next.topic_size : 16'd0;
      result.packet_id        = st_next.msg_id;
      result.payload_length   = (st_next.ptype == TYPE_PUBLISH) ? st_next.pay_len : 28'd0;
      result.end_of_packet    = eop;
      if (st_next.phase == PH_ERR) begin
         result.format_error = FERR_LENGTH;
      end else if (overrun) begin
         result.format_error = FERR_OVERRUN;
      end else begin
         result.format_error = FERR_NONE;
      end
   end

endmodule

### src/mqtt_receive_packet_parser_core.sv
`timescale 1ns / 1ps
// a byte accepted into the input register passes through the parse step into the result
//   register, where its result beat is held until rsp_ready takes it
// throughput: one byte per cycle while the result register drains (rsp_ready high), set by the single parse step
//   between the input register and the result register
// reset: synchronous, active high; parser waits for a flags byte, all decoded
//   fields and the sticky length error clear, both stages empty
// ---------------------------------------------------------------------------
// mqtt_receive_packet_parser_core
// Byte-wide MQTT receive parser: classifies each byte and decodes header fields.
// ---------------------------------------------------------------------------
module mqtt_receive_packet_parser_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_byte_kind,
   output logic [7:0]  rsp_data_byte,
   output logic [3:0]  rsp_packet_type,
   output logic [1:0]  rsp_qos_level,
   output logic [27:0] rsp_remaining_length,
   output logic [15:0] rsp_topic_length,
   output logic [15:0] rsp_message_id,
   output logic [27:0] rsp_payload_length,
   output logic        rsp_end_of_packet,
   output logic [1:0]  rsp_format_error
);
   import mqtt_rx_pkg::*;

   // input stage: one byte beat held here until the parse step takes it
   logic            in_valid_ff, in_valid_in;
   logic [7:0]      in_byte_ff, in_byte_in;
   // parser state, advanced once per byte
   parse_state_type state_ff, state_in;
   // result register
   logic            out_valid_ff, out_valid_in;
   result_type      result_ff, result_in;

   parse_state_type step_state;
   result_type      step_result;
   logic            req_take;
   logic            step_go;

   // step fires when the result register is free or being drained
   assign step_go   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || step_go;
   assign req_take  = req_valid && req_ready;

   mqtt_rx_step_logic u_step (
      .st      (state_ff),
      .rx_byte (in_byte_ff),
      .st_next (step_state),
      .result  (step_result)
   );

   always_comb begin
      in_valid_in  = req_take ? 1'b1 : (step_go ? 1'b0 : in_valid_ff);
      in_byte_in   = req_take ? req_rx_byte : in_byte_ff;
      state_in     = step_go ? step_state : state_ff;
      out_valid_in = step_go ? 1'b1 : (rsp_ready ? 1'b0 : out_valid_ff);
      result_in    = step_go ? step_result : result_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= '{phase: PH_FLAGS, default: '0};
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         state_ff     <= state_in;
      end
   end

   // payload registers, no reset needed
   always_ff @(posedge clock) begin
      in_byte_ff <= in_byte_in;
      result_ff  <= result_in;
   end

   assign rsp_valid            = out_valid_ff;
   assign rsp_byte_kind        = result_ff.byte_kind;
   assign rsp_data_byte        = result_ff.data_byte;
   assign rsp_packet_type      = result_ff.packet_type;
   assign rsp_qos_level        = result_ff.qos_level;
   assign rsp_remaining_length = result_ff.remaining_length;
   assign rsp_topic_length     = result_ff.topic_length;
   assign rsp_message_id       = result_ff.packet_id;
   assign rsp_payload_length   = result_ff.payload_length;
   assign rsp_end_of_packet    = result_ff.end_of_packet;
   assign rsp_format_error     = result_ff.format_error;

   // sticky length error never clears without reset
   a_sticky_error : assert property (@(posedge clock) disable iff (reset)
      state_ff.phase == PH_ERR |=> state_ff.phase == PH_ERR)
      else $error("sticky length error cleared");

   // a byte taken in the flags phase shows up as a flags beat
   a_flags_beat : assert property (@(posedge clock) disable iff (reset)
      step_go && state_ff.phase == PH_FLAGS |=> rsp_valid && rsp_byte_kind == KIND_FLAGS)
      else $error("flags byte not reported as flags");

   // a waiting input beat is neither lost nor overwritten
   a_input_hold : assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !step_go |=> in_valid_ff && $stable(in_byte_ff))
      else $error("input beat lost while stalled");

   // the length error never marks a packet end
   a_err_no_eop : assert property (@(posedge clock) disable iff (reset)
      step_go && step_state.phase == PH_ERR |-> !step_result.end_of_packet)
      else $error("end of packet under length error");

endmodule
